// ----- design/fcp_pkg.sv -----
package fcp_pkg;

   localparam int unsigned CMD_LEN         = 3;
   localparam int unsigned MAX_PARAM_CHARS = 5;
   localparam int unsigned LEN_W           = 4;
   localparam int unsigned MAG_W           = 17;
   localparam int unsigned VAL_W           = 18;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // configuration register indexes
   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_STOP  = 2'd1;

   typedef enum logic [2:0] {
      CMD_RTG = 3'd0,
      CMD_DTG = 3'd1,
      CMD_CTG = 3'd2,
      CMD_PLS = 3'd3,
      CMD_RST = 3'd4,
      CMD_PAU = 3'd5,
      CMD_RES = 3'd6,
      CMD_MSR = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SHORT        = 3'd1,
      ST_UNKNOWN      = 3'd2,
      ST_TOO_LONG     = 3'd3,
      ST_NOT_POSITIVE = 3'd4
   } status_type;

   // what the frame holds at the time the stop byte arrives
   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [23:0]      cmd_bytes;
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } frame_type;

   typedef struct packed {
      cmd_type          code;
      status_type       status;
      logic [VAL_W-1:0] value;
   } result_type;

   function automatic logic [23:0] cmd_word(input cmd_type cmd);
      logic [23:0] w;
      unique case (cmd)
         CMD_RTG: w = "RTG";
         CMD_DTG: w = "DTG";
         CMD_CTG: w = "CTG";
         CMD_PLS: w = "PLS";
         CMD_RST: w = "RST";
         CMD_PAU: w = "PAU";
         CMD_RES: w = "RES";
         CMD_MSR: w = "MSR";
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic takes_param(input cmd_type cmd);
      return (cmd == CMD_DTG) || (cmd == CMD_PLS) || (cmd == CMD_MSR);
   endfunction

endpackage

// ----- design/fcp_eval.sv -----
// Decodes a closed frame into its result item.
module fcp_eval #(
   parameter int unsigned MAX_PARAM_CHARS = fcp_pkg::MAX_PARAM_CHARS
) (
   input  fcp_pkg::frame_type  frame,
   output fcp_pkg::result_type result
);

   localparam logic [fcp_pkg::LEN_W-1:0] LEN_CMD = fcp_pkg::LEN_W'(fcp_pkg::CMD_LEN);
   localparam logic [fcp_pkg::LEN_W-1:0] LEN_LIMIT =
      fcp_pkg::LEN_W'(fcp_pkg::CMD_LEN + MAX_PARAM_CHARS);

   logic             found;
   fcp_pkg::cmd_type match;
   logic [15:0]      low_bits;
   logic [fcp_pkg::VAL_W-1:0] full_val;

   always_comb begin
      found = 1'b0;
      match = fcp_pkg::CMD_RTG;
      for (int k = 0; k < 8; k++) begin
         if (fcp_pkg::cmd_word(fcp_pkg::cmd_type'(k)) == frame.cmd_bytes) begin
            found = 1'b1;
            match = fcp_pkg::cmd_type'(k);
         end
      end
   end

   assign low_bits = frame.negative ? 16'(-frame.magnitude[15:0]) : frame.magnitude[15:0];
   assign full_val = frame.negative ? -{1'b0, frame.magnitude} : {1'b0, frame.magnitude};

   always_comb begin
      result.code   = fcp_pkg::CMD_RTG;
      result.status = fcp_pkg::ST_OK;
      result.value  = '0;
      if (frame.length < LEN_CMD) begin
         result.status = fcp_pkg::ST_SHORT;
      end else if (!found || (!fcp_pkg::takes_param(match) && frame.length != LEN_CMD)) begin
         result.status = fcp_pkg::ST_UNKNOWN;
      end else if (!fcp_pkg::takes_param(match)) begin
         result.code = match;
      end else begin
         result.code = match;
         if (frame.length > LEN_LIMIT) begin
            result.status = fcp_pkg::ST_TOO_LONG;
         end else if (match == fcp_pkg::CMD_MSR) begin
            result.value  = {2'b00, low_bits};
            result.status = (low_bits != '0) ? fcp_pkg::ST_OK : fcp_pkg::ST_NOT_POSITIVE;
         end else begin
            result.value  = full_val;
            result.status = (!frame.negative && frame.magnitude != '0) ?
                            fcp_pkg::ST_OK : fcp_pkg::ST_NOT_POSITIVE;
         end
      end
   end

endmodule

// ----- design/framed_ascii_command_parser.sv -----
// Channel   Direction  Payload
// req_      in         tdata[7:0] rx_byte
// rsp_      out        tuser[2:0] command_code; tdata[2:0] frame_status,
//                      tdata[20:3] param_value, tdata[23:21] zero
// csr_      in         index 0 start_char, index 1 stop_char (data[7:0])
//
// One byte per cycle while req_tready is high: a byte that is taken inside a
// frame, or is a start byte, updates the frame state in the cycle it is taken;
// a stop byte in a frame loads the decoded result into the output register,
// and rsp_tvalid rises in the next cycle. A single output register holds the
// result; req_tready drops only while that register is full and rsp_tready is
// low. Synchronous active-high reset; start_char resets to '$', stop_char to '#'.
module framed_ascii_command_parser #(
   parameter int unsigned MAX_PARAM_CHARS = fcp_pkg::MAX_PARAM_CHARS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] frame_status, [20:3] param_value, [23:21] zero
   output logic [2:0]  rsp_tuser,   // [2:0] command_code

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam logic [fcp_pkg::LEN_W-1:0] LEN_CMD = fcp_pkg::LEN_W'(fcp_pkg::CMD_LEN);
   localparam logic [fcp_pkg::LEN_W-1:0] LEN_LIMIT =
      fcp_pkg::LEN_W'(fcp_pkg::CMD_LEN + MAX_PARAM_CHARS);

   typedef enum logic [1:0] {
      PHASE_WS     = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   logic [7:0]          start_ff, start_in;
   logic [7:0]          stop_ff, stop_in;
   logic                in_frame_ff, in_frame_in;
   phase_type           phase_ff, phase_in;
   fcp_pkg::frame_type  frame_ff, frame_in;
   logic                rsp_valid_ff, rsp_valid_in;
   fcp_pkg::result_type rsp_ff, rsp_in;

   fcp_pkg::result_type result;

   logic       req_acc;
   logic       closing;
   logic [7:0] b;
   logic       is_digit;
   logic       is_space;
   logic [3:0] digit;
   logic [20:0] mag_next;
   logic [fcp_pkg::MAG_W-1:0] mag_sat;

   fcp_eval #(
      .MAX_PARAM_CHARS (MAX_PARAM_CHARS)
   ) u_eval (
      .frame  (frame_ff),
      .result (result)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign closing    = req_acc && in_frame_ff && (b == stop_ff);

   assign is_digit = (b >= "0") && (b <= "9");
   assign is_space = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   assign digit    = 4'(b - "0");
   // magnitude * 10 + digit, saturated to the field width
   assign mag_next = {1'b0, frame_ff.magnitude, 3'b000} + {3'b000, frame_ff.magnitude, 1'b0}
                     + {17'd0, digit};
   assign mag_sat  = (mag_next > {4'd0, fcp_pkg::MAG_MAX}) ? fcp_pkg::MAG_MAX
                                                           : mag_next[fcp_pkg::MAG_W-1:0];

   assign csr_ready = 1'b1;

   always_comb begin
      start_in = start_ff;
      stop_in  = stop_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fcp_pkg::CSR_START: start_in = csr_data;
            fcp_pkg::CSR_STOP:  stop_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      phase_in    = phase_ff;
      frame_in    = frame_ff;
      if (closing) begin
         in_frame_in = 1'b0;
      end else if (req_acc && (b == start_ff)) begin
         in_frame_in = 1'b1;
         phase_in    = PHASE_WS;
         frame_in    = '0;
      end else if (req_acc && in_frame_ff) begin
         if (frame_ff.length < LEN_CMD) begin
            frame_in.cmd_bytes = {frame_ff.cmd_bytes[15:0], b};
         end else if (frame_ff.length < LEN_LIMIT) begin
            // atoi-style: whitespace, optional sign, then digits
            unique case (phase_ff)
               PHASE_WS: begin
                  if (is_space) begin
                     phase_in = PHASE_WS;
                  end else if ((b == "+") || (b == "-")) begin
                     frame_in.negative = (b == "-");
                     phase_in          = PHASE_DIGITS;
                  end else if (is_digit) begin
                     frame_in.magnitude = mag_sat;
                     phase_in           = PHASE_DIGITS;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               PHASE_DIGITS: begin
                  if (is_digit) begin
                     frame_in.magnitude = mag_sat;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
         if (frame_ff.length != fcp_pkg::LEN_MAX) begin
            frame_in.length = frame_ff.length + fcp_pkg::LEN_W'(1);
         end
      end
   end

   assign rsp_valid_in = closing || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = closing ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= "$";
         stop_ff      <= "#";
         in_frame_ff  <= 1'b0;
         phase_ff     <= PHASE_WS;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         in_frame_ff  <= in_frame_in;
         phase_ff     <= phase_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.code;
   assign rsp_tdata  = {3'b000, rsp_ff.value, rsp_ff.status};

endmodule

// ----- verif/framed_ascii_command_parser_checker.sv -----
`timescale 1ns / 1ps

// Watches the byte, result and register channels, keeps its own copy of the
// frame state and compares every result with the oldest one it predicted.
module framed_ascii_command_parser_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,

   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,

   output int          mismatches,
   output int          pending,
   output int          results_checked,
   output logic [4:0]  statuses_seen
);

   typedef enum logic [1:0] {
      SKIP_WS,
      IN_DIGITS,
      PARSE_DONE
   } parse_type;

   localparam logic [23:0] MNEMONICS [8] =
      '{"RTG", "DTG", "CTG", "PLS", "RST", "PAU", "RES", "MSR"};
   // commands that read a parameter: DTG, PLS, MSR
   localparam logic [7:0] WITH_PARAM = 8'b1000_1010;

   logic [7:0]  start_sym;
   logic [7:0]  stop_sym;
   logic        open_q;
   logic [3:0]  body_len;
   logic [23:0] cmd_text;
   parse_type   phase_q;
   logic        neg_q;
   logic [16:0] mag_q;

   fcp_pkg::result_type frame_results[$];

   initial begin
      mismatches      = 0;
      pending         = 0;
      results_checked = 0;
      statuses_seen   = '0;
   end

   function automatic void add_digit(input logic [7:0] ch);
      int unsigned m;
      m = 32'(mag_q) * 10 + 32'(ch - "0");
      mag_q = (m > 32'(fcp_pkg::MAG_MAX)) ? fcp_pkg::MAG_MAX : m[16:0];
   endfunction

   // atoi-style scan: blanks, optional sign, digits up to the first other byte
   function automatic void scan_param(input logic [7:0] ch);
      logic digit;
      logic blank;
      digit = (ch >= "0") && (ch <= "9");
      blank = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
      case (phase_q)
         SKIP_WS: begin
            if (ch == "+" || ch == "-") begin
               neg_q   = (ch == "-");
               phase_q = IN_DIGITS;
            end else if (digit) begin
               add_digit(ch);
               phase_q = IN_DIGITS;
            end else if (!blank) begin
               phase_q = PARSE_DONE;
            end
         end
         IN_DIGITS: begin
            if (digit) add_digit(ch);
            else phase_q = PARSE_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic fcp_pkg::result_type decode_frame();
      fcp_pkg::result_type r;
      int          hit;
      logic [15:0] low16;
      r.code   = fcp_pkg::CMD_RTG;
      r.status = fcp_pkg::ST_OK;
      r.value  = '0;
      hit      = -1;
      if (body_len < fcp_pkg::CMD_LEN) begin
         r.status = fcp_pkg::ST_SHORT;
      end else begin
         for (int k = 0; k < 8; k++)
            if (MNEMONICS[k] == cmd_text) hit = k;
         if (hit < 0 || (!WITH_PARAM[hit] && body_len != fcp_pkg::CMD_LEN)) begin
            r.status = fcp_pkg::ST_UNKNOWN;
         end else begin
            r.code = fcp_pkg::cmd_type'(hit[2:0]);
            if (!WITH_PARAM[hit]) begin
               r.status = fcp_pkg::ST_OK;
            end else if (32'(body_len) - fcp_pkg::CMD_LEN > fcp_pkg::MAX_PARAM_CHARS) begin
               r.status = fcp_pkg::ST_TOO_LONG;
            end else if (r.code == fcp_pkg::CMD_MSR) begin
               low16    = neg_q ? 16'd0 - mag_q[15:0] : mag_q[15:0];
               r.value  = {2'b00, low16};
               r.status = (low16 != 0) ? fcp_pkg::ST_OK : fcp_pkg::ST_NOT_POSITIVE;
            end else begin
               r.value  = neg_q ? 18'd0 - {1'b0, mag_q} : {1'b0, mag_q};
               r.status = (!neg_q && mag_q != 0) ? fcp_pkg::ST_OK : fcp_pkg::ST_NOT_POSITIVE;
            end
         end
      end
      return r;
   endfunction

   function automatic void absorb_byte(input logic [7:0] ch);
      if (open_q && ch == stop_sym) begin
         frame_results.push_back(decode_frame());
         open_q = 1'b0;
      end else if (ch == start_sym) begin
         open_q   = 1'b1;
         body_len = '0;
         cmd_text = '0;
         phase_q  = SKIP_WS;
         neg_q    = 1'b0;
         mag_q    = '0;
      end else if (open_q) begin
         if (body_len < fcp_pkg::CMD_LEN) cmd_text = {cmd_text[15:0], ch};
         else if (32'(body_len) - fcp_pkg::CMD_LEN < fcp_pkg::MAX_PARAM_CHARS) scan_param(ch);
         if (body_len != fcp_pkg::LEN_MAX) body_len++;
      end
   endfunction

   function automatic void report(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
   endfunction

   always @(posedge clock) begin
      fcp_pkg::result_type want;
      if (reset) begin
         start_sym = 8'h24;
         stop_sym  = 8'h23;
         open_q    = 1'b0;
         body_len  = '0;
         cmd_text  = '0;
         phase_q   = SKIP_WS;
         neg_q     = 1'b0;
         mag_q     = '0;
         frame_results.delete();
      end else begin
         // result first: it always belongs to an older frame than a byte taken now
         if (rsp_tvalid && rsp_tready) begin
            if (frame_results.size() == 0) begin
               report($sformatf("result with nothing expected: code %0d status %0d value 0x%05h",
                                rsp_tuser, rsp_tdata[2:0], rsp_tdata[20:3]));
            end else begin
               want = frame_results.pop_front();
               results_checked++;
               statuses_seen[want.status] = 1'b1;
               if (rsp_tuser !== want.code || rsp_tdata[2:0] !== want.status ||
                   rsp_tdata[20:3] !== want.value || rsp_tdata[23:21] !== 3'b000)
                  report($sformatf({"expected code %0d status %0d value 0x%05h, ",
                                    "got code %0d status %0d value 0x%05h pad %0d"},
                                   want.code, want.status, want.value, rsp_tuser,
                                   rsp_tdata[2:0], rsp_tdata[20:3], rsp_tdata[23:21]));
            end
         end
         // a byte taken in the same cycle as a write still sees the old delimiters
         if (req_tvalid && req_tready) absorb_byte(req_tdata);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fcp_pkg::CSR_START: start_sym = csr_data;
               fcp_pkg::CSR_STOP:  stop_sym  = csr_data;
               default: ;
            endcase
         end
      end
      pending = frame_results.size();
   end

endmodule

// ----- verif/framed_ascii_command_parser_test.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the framed command parser. A directed set of
// frames comes first under the reset delimiters, then random frames under
// a series of delimiter settings. Prediction and comparison live in the
// checker instantiated beside the block.
module framed_ascii_command_parser_test;

   localparam int STALL_PCT      = 11;     // idle chance per cycle, both sides
   localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake at all
   localparam int RANDOM_BYTES   = 336;
   localparam int SETTINGS_N     = 6;
   localparam int SETTLE_CYCLES  = 4;      // the result is registered when the stop byte is taken

   localparam logic [1:0] CSR_SPARE = 2'd2;  // no register behind this index

   // delimiter pairs per random phase: reset values, the extremes both ways,
   // printable brackets, start equal to stop, and whitespace bytes
   localparam logic [7:0] OPENERS [SETTINGS_N] = '{8'h24, 8'h00, 8'hFF, 8'h3C, 8'h21, 8'h0A};
   localparam logic [7:0] CLOSERS [SETTINGS_N] = '{8'h23, 8'hFF, 8'h00, 8'h3E, 8'h21, 8'h0D};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;     // [7:0] rx_byte

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [2:0] frame_status, [20:3] param_value, [23:21] zero
   logic [2:0]  rsp_tuser;           // [2:0] command_code

   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [7:0]  csr_data   = '0;

   int          mismatches;
   int          pending;
   int          results_checked;
   logic [4:0]  statuses_seen;

   // stimulus-side copy of the delimiters, used only to build frames
   logic [7:0]  start_sym  = 8'h24;
   logic [7:0]  stop_sym   = 8'h23;
   logic        calm       = 1'b0;   // no idling on either side while set
   int          bytes_sent = 0;
   int          reg_writes = 0;
   int          quiet_cycles = 0;

   always #10 clock = ~clock;

   framed_ascii_command_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   framed_ascii_command_parser_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked),
      .statuses_seen   (statuses_seen)
   );

   // Result side: random back-pressure, none while calm.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= STALL_PCT);
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, pending);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One byte into the parser. Valid stays high into the next item; it is
   // only lowered for an idle gap or when a phase ends.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_frame(input string body);
      send_byte(start_sym);
      send_text(body);
      send_byte(stop_sym);
   endtask

   // Register write; valid is left high so back-to-back writes need no toggle.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
   endtask

   task automatic program_delimiters(input logic [7:0] opener, input logic [7:0] closer);
      write_reg(fcp_pkg::CSR_START, opener);
      write_reg(fcp_pkg::CSR_STOP, closer);
      csr_valid <= 1'b0;
      start_sym = opener;
      stop_sym  = closer;
   endtask

   // Wait for every predicted result, then give the last stop byte time to land.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Parameter text: optional blanks, optional sign, digits, sometimes junk.
   // Lengths run past the five-character limit now and then.
   task automatic random_param();
      int digits;
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(2, 1))
            send_byte(($urandom_range(2) == 0) ? 8'd32 : 8'($urandom_range(13, 9)));
      case ($urandom_range(9))
         0: send_byte("-");
         1: send_byte("+");
         default: ;
      endcase
      digits = ($urandom_range(9) < 8) ? $urandom_range(5, 1) : $urandom_range(7, 0);
      repeat (digits) send_byte(8'("0" + $urandom_range(9)));
      if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
   endtask

   // Mostly well-formed frames with random content; the rest is noise,
   // frames cut off by a restart, and stray bytes between frames.
   task automatic random_frame();
      int               kind;
      fcp_pkg::cmd_type cmd;
      logic [23:0]      word;
      kind = $urandom_range(99);
      if (kind < 72) begin
         cmd  = fcp_pkg::cmd_type'($urandom_range(7));
         word = fcp_pkg::cmd_word(cmd);
         if ($urandom_range(9) == 0)
            word[8*$urandom_range(2) +: 8] = 8'("A" + $urandom_range(25));
         send_byte(start_sym);
         send_byte(word[23:16]);
         send_byte(word[15:8]);
         send_byte(word[7:0]);
         if (cmd == fcp_pkg::CMD_DTG || cmd == fcp_pkg::CMD_PLS || cmd == fcp_pkg::CMD_MSR)
            random_param();
         else if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
         send_byte(stop_sym);
      end else if (kind < 86) begin
         // any byte value in the body, long enough at times to saturate the length
         send_byte(start_sym);
         repeat ($urandom_range(18)) send_byte(8'($urandom_range(255)));
         send_byte(stop_sym);
      end else if (kind < 93) begin
         // opened and never closed: the next start restarts it
         send_byte(start_sym);
         repeat ($urandom_range(6)) send_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed frames under the reset delimiters '$' and '#' ----
      send_text("#zz");                 // stray bytes and a stop outside a frame
      send_frame("RTG");
      send_frame("CTG");
      send_frame("RST");
      send_frame("PAU");
      send_frame("RES");
      send_frame("DTG7");
      send_frame("PLS  +42");           // blanks and plus sign
      send_frame("DTG99999");           // largest five-digit value
      send_frame("MSR65535");
      send_frame("MSR65536");           // low 16 bits zero: not positive
      send_frame("MSR-1");              // wraps to 0xFFFF
      send_frame("DTG-5");              // negative: not positive, value kept
      send_frame("PLS");                // empty parameter counts as zero
      send_frame("DTG-");               // sign only
      send_frame("DTG\t12ab");          // tab, then digits ended by junk
      send_frame("PLS123456");          // six parameter characters
      send_frame("DTG123456789012345"); // body length saturates
      send_frame("RT");                 // short body
      send_frame("");                   // empty body
      send_frame("XYZ");                // no such command
      send_frame("RTG1");               // parameterless command with a parameter
      send_text("$PLS9$DTG3#");         // restart inside an open frame
      settle();

      // the spare index has no register behind it
      write_reg(CSR_SPARE, 8'h5A);
      csr_valid <= 1'b0;

      // ---- random frames, one delimiter setting per phase ----
      for (int p = 0; p < SETTINGS_N; p++) begin
         settle();
         program_delimiters(OPENERS[p], CLOSERS[p]);
         calm   = (p == 3);             // one phase runs flat out
         target = bytes_sent + RANDOM_BYTES / SETTINGS_N;
         while (bytes_sent < target) random_frame();
      end
      calm = 1'b0;

      settle();
      @(negedge clock);
      $display("%0d bytes sent, %0d register writes, %0d delimiter settings",
               bytes_sent, reg_writes, SETTINGS_N + 1);
      $display("%0d results compared, %0d mismatches, frame statuses seen %05b",
               results_checked, mismatches, statuses_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/fcp_pkg.sv
design/fcp_eval.sv
design/framed_ascii_command_parser.sv
verif/framed_ascii_command_parser_checker.sv
verif/framed_ascii_command_parser_test.sv
